@@ sv/tlc_pkg.sv @@
// Shared types, constants and helper functions for the traffic light controller.
// Used by tlc_step and traffic_light_controller_with_setup_core; no dependencies.
package tlc_pkg;

  localparam logic [7:0] MAX_TIME  = 8'd99;
  localparam logic [7:0] MIN_TIME  = 8'd1;
  localparam logic [7:0] LONG_STEP = 8'd10;

  localparam logic [7:0] RED_RESET    = 8'd5;
  localparam logic [7:0] YELLOW_RESET = 8'd2;
  localparam logic [7:0] GREEN_RESET  = 8'd3;

  localparam logic [2:0] LAMP_OFF = 3'b000;
  localparam logic [2:0] LAMP_RED = 3'b100;
  localparam logic [2:0] LAMP_YEL = 3'b010;
  localparam logic [2:0] LAMP_GRN = 3'b001;

  // Command codes carried on the input side band.
  localparam logic [1:0] CMD_POLL  = 2'd0;
  localparam logic [1:0] CMD_SEC   = 2'd1;
  localparam logic [1:0] CMD_BLINK = 2'd2;

  // Phase codes, also shown on the mode output.
  localparam logic [2:0] PH_INIT      = 3'd0;
  localparam logic [2:0] PH_RED_GRN   = 3'd1;
  localparam logic [2:0] PH_RED_YEL   = 3'd2;
  localparam logic [2:0] PH_GRN_RED   = 3'd3;
  localparam logic [2:0] PH_YEL_RED   = 3'd4;
  localparam logic [2:0] PH_SET_RED   = 3'd5;
  localparam logic [2:0] PH_SET_YEL   = 3'd6;
  localparam logic [2:0] PH_SET_GRN   = 3'd7;

  typedef struct packed {
    logic       mode_pressed;
    logic       inc_pressed;
    logic       inc_long_pressed;
    logic       set_pressed;
  } buttons_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] count_horizontal;
    logic [7:0] count_vertical;
    logic [7:0] red_seconds;
    logic [7:0] yellow_seconds;
    logic [7:0] green_seconds;
    logic [7:0] edited_seconds;
    logic [2:0] lamp_horizontal;
    logic [2:0] lamp_vertical;
  } ctl_state_t;

  function automatic logic [7:0] sat_add(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(logic [7:0] a, logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

  // Add a step to the edited time, wrapping to the minimum past the maximum.
  function automatic logic [7:0] bump(logic [7:0] a, logic [7:0] step);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, step};
    return (s > {1'b0, MAX_TIME}) ? MIN_TIME : s[7:0];
  endfunction

endpackage

@@ sv/tlc_step.sv @@
// Next-state logic of the traffic light controller for one command beat.
// Depends on tlc_pkg.
module tlc_step (
  input  tlc_pkg::ctl_state_t cur,
  input  logic [1:0]          command,
  input  tlc_pkg::buttons_t   buttons,
  output tlc_pkg::ctl_state_t nxt
);
  import tlc_pkg::*;

  function automatic ctl_state_t load_counts(ctl_state_t s, logic [7:0] h, logic [7:0] v,
                                             logic [2:0] lh, logic [2:0] lv,
                                             logic [2:0] ph);
    ctl_state_t r;
    r = s;
    r.count_horizontal = h;
    r.count_vertical   = v;
    r.lamp_horizontal  = lh;
    r.lamp_vertical    = lv;
    r.phase            = ph;
    return r;
  endfunction

  function automatic ctl_state_t enter_setup(ctl_state_t s, logic [2:0] ph);
    ctl_state_t r;
    logic [2:0] lamp;
    r = s;
    case (ph)
      PH_SET_RED: begin
        r.edited_seconds = s.red_seconds;
        lamp = LAMP_RED;
      end
      PH_SET_YEL: begin
        r.edited_seconds = s.yellow_seconds;
        lamp = LAMP_YEL;
      end
      default: begin
        r.edited_seconds = s.green_seconds;
        lamp = LAMP_GRN;
      end
    endcase
    return load_counts(r, r.edited_seconds, 8'd0, lamp, lamp, ph);
  endfunction

  function automatic ctl_state_t start_cycle(ctl_state_t s);
    return load_counts(s, s.red_seconds, s.green_seconds, LAMP_RED, LAMP_GRN, PH_RED_GRN);
  endfunction

  ctl_state_t s;
  logic       hz;
  logic       vz;
  logic [2:0] blink_bit;

  always_comb begin
    s = cur;
    hz = (cur.count_horizontal == 8'd0);
    vz = (cur.count_vertical == 8'd0);
    blink_bit = LAMP_OFF;
    case (command)
      CMD_POLL: begin
        case (cur.phase)
          PH_INIT: s = start_cycle(s);
          PH_RED_GRN: begin
            if (vz) begin
              s = load_counts(s, sat_sub(s.red_seconds, s.green_seconds), s.yellow_seconds,
                              LAMP_RED, LAMP_YEL, PH_RED_YEL);
            end else if (buttons.mode_pressed) begin
              s = enter_setup(s, PH_SET_RED);
            end
          end
          PH_RED_YEL: begin
            if (hz && vz) begin
              s = load_counts(s, s.green_seconds, s.red_seconds, LAMP_GRN, LAMP_RED,
                              PH_GRN_RED);
            end else if (buttons.mode_pressed) begin
              s = enter_setup(s, PH_SET_RED);
            end
          end
          PH_GRN_RED: begin
            if (hz) begin
              s = load_counts(s, s.yellow_seconds, sat_sub(s.red_seconds, s.green_seconds),
                              LAMP_YEL, LAMP_RED, PH_YEL_RED);
            end else if (buttons.mode_pressed) begin
              s = enter_setup(s, PH_SET_RED);
            end
          end
          PH_YEL_RED: begin
            if (hz && vz) begin
              s = start_cycle(s);
            end else if (buttons.mode_pressed) begin
              s = enter_setup(s, PH_SET_RED);
            end
          end
          default: begin
            // Setup modes: short press first, then long press.
            if (buttons.inc_pressed) begin
              s.edited_seconds   = bump(s.edited_seconds, 8'd1);
              s.count_horizontal = s.edited_seconds;
            end
            if (buttons.inc_long_pressed) begin
              s.edited_seconds   = bump(s.edited_seconds, LONG_STEP);
              s.count_horizontal = s.edited_seconds;
            end
            if (buttons.mode_pressed) begin
              if (cur.phase == PH_SET_GRN) begin
                s = start_cycle(s);
              end else begin
                s = enter_setup(s, cur.phase + 3'd1);
              end
            end else if (buttons.set_pressed) begin
              case (cur.phase)
                PH_SET_RED: begin
                  if (s.edited_seconds > s.yellow_seconds) begin
                    s.red_seconds   = s.edited_seconds;
                    s.green_seconds = sat_sub(s.edited_seconds, s.yellow_seconds);
                  end
                end
                PH_SET_YEL: begin
                  if (s.edited_seconds >= s.red_seconds) begin
                    s.red_seconds = sat_add(s.edited_seconds, s.green_seconds);
                  end else begin
                    s.green_seconds = sat_sub(s.red_seconds, s.edited_seconds);
                  end
                  s.yellow_seconds = s.edited_seconds;
                end
                default: begin
                  s.green_seconds = s.edited_seconds;
                  s.red_seconds   = sat_add(s.edited_seconds, s.yellow_seconds);
                end
              endcase
              s = enter_setup(s, cur.phase);
            end
          end
        endcase
      end
      CMD_SEC: begin
        if (cur.phase inside {[PH_RED_GRN:PH_YEL_RED]}) begin
          if (!hz) s.count_horizontal = cur.count_horizontal - 8'd1;
          if (!vz) s.count_vertical   = cur.count_vertical - 8'd1;
        end
      end
      CMD_BLINK: begin
        case (cur.phase)
          PH_SET_RED: blink_bit = LAMP_RED;
          PH_SET_YEL: blink_bit = LAMP_YEL;
          PH_SET_GRN: blink_bit = LAMP_GRN;
          default:    blink_bit = LAMP_OFF;
        endcase
        s.lamp_horizontal = cur.lamp_horizontal ^ blink_bit;
        s.lamp_vertical   = cur.lamp_vertical ^ blink_bit;
      end
      default: s = cur;
    endcase
    nxt = s;
  end

endmodule

@@ sv/traffic_light_controller_with_setup_core.sv @@
// Top level of the two-road traffic light controller with setup modes.
// Depends on tlc_pkg and tlc_step.
//
// The block takes one command beat per clock on the slave stream while the master side
// keeps up (a control poll with button flags, a one-second tick or a blink tick) and
// returns, for every beat, one status beat on the master stream holding both lamp sets,
// both displays and the current mode. A beat passes through an input register and then
// a result register, and the status is valid on the master side once the result register
// holds it; with the master side ready one beat is taken and one delivered every clock. The
// controller state (phase, countdowns, stored red/yellow/green times, edited time and
// lamps) is updated in the same cycle the beat moves from the input register to the
// result register, by the next-state logic in tlc_step. After reset the block sits in
// the init phase with all lamps off; the first control poll starts the automatic
// cycle. Command code 3 changes nothing and simply reports the current status.
module traffic_light_controller_with_setup_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: mode_pressed, inc_pressed, inc_long_pressed, set_pressed.
  input  logic [7:0]  s_tdata,
  // Fields from bit 0: command.
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: lamps_horizontal[2:0], lamps_vertical[5:3],
  // display_horizontal[13:6], display_vertical[21:14], mode[24:22].
  output logic [31:0] m_tdata
);
  import tlc_pkg::*;

  // Input register.
  logic       in_valid;
  logic [1:0] in_command;
  buttons_t   in_buttons;

  // Controller state and its next value.
  ctl_state_t state;
  ctl_state_t state_next;

  // Result register.
  logic       out_valid;
  logic [31:0] out_data;

  logic advance;

  // A beat moves on when the result register is empty or being drained.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  tlc_step u_step (
    .cur     (state),
    .command (in_command),
    .buttons (in_buttons),
    .nxt     (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state.phase            <= PH_INIT;
      state.count_horizontal <= 8'd0;
      state.count_vertical   <= 8'd0;
      state.red_seconds      <= RED_RESET;
      state.yellow_seconds   <= YELLOW_RESET;
      state.green_seconds    <= GREEN_RESET;
      state.edited_seconds   <= 8'd0;
      state.lamp_horizontal  <= LAMP_OFF;
      state.lamp_vertical    <= LAMP_OFF;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_command                  <= s_tuser;
      in_buttons.mode_pressed     <= s_tdata[0];
      in_buttons.inc_pressed      <= s_tdata[1];
      in_buttons.inc_long_pressed <= s_tdata[2];
      in_buttons.set_pressed      <= s_tdata[3];
    end
    if (advance) begin
      out_data <= {7'd0, state_next.phase, state_next.count_vertical,
                   state_next.count_horizontal, state_next.lamp_vertical,
                   state_next.lamp_horizontal};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
